@@ src/mbss_pkg.sv @@
// shared types and constants of the masked byte signature scanner
`default_nettype none

package mbss_pkg;

   // default sizing handed to the top level parameters
   localparam int PATTERN_MAX_DEF = 16;
   localparam int OFFSET_BITS_DEF = 32;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 64;
   localparam int CARE_W     = 16;
   localparam int LENGTH_W   = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   // rel32 operand of a rip-relative instruction
   localparam int DISP_POS   = 3;   // displacement starts three bytes into the match
   localparam int DISP_BYTES = 4;
   localparam int DISP_W     = DISP_BYTES * BYTE_W;
   localparam int INSN_LEN   = 7;   // target is relative to the end of the instruction
   localparam int DISP_LAST  = INSN_LEN - 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_BITS    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_RELATIVE     = 3'd4,
      CSR_REGION_START = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   pattern_low_bytes;
      logic [ADDR_W-1:0]   pattern_high_bytes;
      logic [CARE_W-1:0]   care_bits;
      logic [LENGTH_W-1:0] pattern_length;
      logic                relative_mode;
      logic [ADDR_W-1:0]   region_start;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pattern_low_bytes:  '0,
      pattern_high_bytes: '0,
      care_bits:          '0,
      pattern_length:     LENGTH_W'(1),
      relative_mode:      1'b0,
      region_start:       '0
   };

   // hit handed from the scan stage to the address stage
   typedef struct packed {
      logic              found;
      logic              use_disp;
      logic [ADDR_W-1:0] offset;
      logic [DISP_W:0]   disp_sum;   // sign-extended rel32 plus instruction length
   } rslv_type;

endpackage

`default_nettype wire

@@ src/mbss_req_if.sv @@
// byte channel into the scanner
`default_nettype none

interface mbss_req_if import mbss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ src/mbss_rsp_if.sv @@
// result channel out of the scanner
`default_nettype none

interface mbss_rsp_if import mbss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

@@ src/masked_byte_signature_scanner.sv @@
// top level of the masked byte signature scanner
//
// bytes of one code region arrive on req_bus, one beat per byte in address
// order, with last_byte set on the final byte. the block looks for the first
// offset where the configured pattern (up to sixteen bytes, each compared or
// ignored by its care bit) matches and returns a single beat on rsp_bus per
// region: region_start plus offset, or in relative mode region_start + offset
// + rel32 + 7 with rel32 the signed little-endian word at offset+3 (the
// plain address if the region ends first). a region without a match returns
// found=0 and address 0 on its last byte. later bytes of a region after its
// result are swallowed. the block takes one byte per cycle unless a held result
// on the result side stalls it; the per-byte window compare is combinational
// in the scan stage. a result beat passes the input register, the scan stage
// and the address adder into the output register. configuration writes land
// on csr_we and apply from the next byte on; write them only while no byte or
// result is in flight.
`default_nettype none

module masked_byte_signature_scanner import mbss_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,   // window depth, longest usable pattern
   parameter int OFFSET_BITS = OFFSET_BITS_DEF    // width of the byte position counter
) (
   input  logic                  clock,
   input  logic                  reset,
   mbss_req_if.sink              req_bus,
   mbss_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg;

   // scan stage to address stage
   logic     hit_valid;
   logic     hit_ready;
   rslv_type hit;

   // register file, reset leaves a one byte don't-care pattern
   mbss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // window shift, parallel masked compare, match tracking and rel32 pick
   mbss_scan #(
      .PATTERN_MAX (PATTERN_MAX),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_bus),
      .hit_valid (hit_valid),
      .hit_ready (hit_ready),
      .hit       (hit)
   );

   // final 64-bit sum, wraps modulo 2^64, held until the sink takes it
   mbss_resolve u_resolve (
      .clock        (clock),
      .reset        (reset),
      .region_start (cfg.region_start),
      .hit_valid    (hit_valid),
      .hit_ready    (hit_ready),
      .hit          (hit),
      .rsp          (rsp_bus)
   );

endmodule

`default_nettype wire

@@ src/mbss_csr.sv @@
// configuration registers of the scanner
`default_nettype none

module mbss_csr import mbss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  cfg_in.pattern_low_bytes  = csr_data;
            CSR_PATTERN_HIGH: cfg_in.pattern_high_bytes = csr_data;
            CSR_CARE_BITS:    cfg_in.care_bits          = csr_data[CARE_W-1:0];
            CSR_PATTERN_LEN:  cfg_in.pattern_length     = csr_data[LENGTH_W-1:0];
            CSR_RELATIVE:     cfg_in.relative_mode      = csr_data[0];
            CSR_REGION_START: cfg_in.region_start       = csr_data;
            default:          cfg_in = cfg_ff;   // unused index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/mbss_scan.sv @@
// input register, byte window compare and scan state
`default_nettype none

module mbss_scan import mbss_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   mbss_req_if.sink  req,
   output logic      hit_valid,
   input  logic      hit_ready,
   output rslv_type  hit
);

   localparam int LenW    = $clog2(PATTERN_MAX + 1);
   localparam int IdxW    = $clog2(PATTERN_MAX);
   localparam int PatBits = BYTE_W * PATTERN_MAX;

   // input register
   logic              in_vld_ff;
   logic              in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // scan state
   logic [BYTE_W-1:0]      win_ff [PATTERN_MAX];
   logic [BYTE_W-1:0]      win_nx [PATTERN_MAX];
   logic [OFFSET_BITS-1:0] bytes_seen_ff;
   logic                   match_pending_ff;
   logic [OFFSET_BITS-1:0] match_off_ff;
   logic                   scan_done_ff;

   // hit register
   logic     hit_vld_ff;
   logic     hit_vld_in;
   rslv_type hit_ff;
   rslv_type hit_in;

   logic                   hit_free;
   logic                   core_go;
   logic [PatBits-1:0]     pat_flat;
   logic [PATTERN_MAX-1:0] care_flat;
   logic [LenW-1:0]        eff_len;
   logic [IdxW-1:0]        len_m1;
   logic [PATTERN_MAX-1:0] len_hit;
   logic [OFFSET_BITS-1:0] diff;
   logic [OFFSET_BITS-1:0] new_off;
   logic [OFFSET_BITS-1:0] off_after;
   logic [DISP_W-1:0]      disp_word;
   logic                   active;
   logic                   new_match;
   logic                   pend_now;
   logic                   pend_after;
   logic                   emit_plain;
   logic                   emit_rel;
   logic                   emit_scan;
   logic                   emit_final;
   logic                   emit;

   assign hit_free  = !hit_vld_ff || hit_ready;
   assign core_go   = in_vld_ff && hit_free;
   assign req.ready = !in_vld_ff || hit_free;
   assign in_vld_in = req.ready ? req.valid : in_vld_ff;

   // pattern bytes past the configured sixteen read as zero, don't care
   assign pat_flat  = PatBits'({cfg.pattern_high_bytes, cfg.pattern_low_bytes});
   assign care_flat = PATTERN_MAX'(cfg.care_bits);

   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = LenW'(1);
      end else if (int'(cfg.pattern_length) > PATTERN_MAX) begin
         eff_len = LenW'(PATTERN_MAX);
      end else begin
         eff_len = LenW'(cfg.pattern_length);
      end
   end
   assign len_m1 = IdxW'(eff_len - LenW'(1));

   // window after this byte shifts in, newest at index 0
   always_comb begin
      win_nx[0] = in_byte_ff;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         win_nx[i] = win_ff[i-1];
      end
   end

   // one compare per candidate length, the configured one is picked below
   always_comb begin
      for (int l = 0; l < PATTERN_MAX; l++) begin
         len_hit[l] = 1'b1;
         for (int k = 0; k <= l; k++) begin
            if (care_flat[k] && (win_nx[l-k] != pat_flat[BYTE_W*k +: BYTE_W])) begin
               len_hit[l] = 1'b0;
            end
         end
      end
   end

   assign active    = !scan_done_ff && (bytes_seen_ff != '1);
   assign new_off   = bytes_seen_ff - OFFSET_BITS'(len_m1);
   assign new_match = active && !match_pending_ff &&
                      (bytes_seen_ff >= OFFSET_BITS'(len_m1)) && len_hit[len_m1];
   assign pend_now  = active && (match_pending_ff || new_match);
   assign off_after = new_match ? new_off : match_off_ff;

   // distance from the match start to the current byte
   assign diff = match_pending_ff ? (bytes_seen_ff - match_off_ff) : OFFSET_BITS'(len_m1);

   // rel32 taps, the oldest byte of the word sits deepest in the window
   always_comb begin
      logic sel;
      disp_word = '0;
      for (int j = DISP_POS; j < PATTERN_MAX; j++) begin
         if (j == PATTERN_MAX - 1) begin
            sel = diff >= OFFSET_BITS'(j + DISP_POS);
         end else begin
            sel = diff == OFFSET_BITS'(j + DISP_POS);
         end
         if (sel) begin
            for (int b = 0; b < DISP_BYTES; b++) begin
               disp_word[BYTE_W*b +: BYTE_W] = win_nx[j-b];
            end
         end
      end
   end

   assign emit_plain = pend_now && !cfg.relative_mode;
   assign emit_rel   = pend_now && cfg.relative_mode && (diff >= OFFSET_BITS'(DISP_LAST));
   assign emit_scan  = emit_plain || emit_rel;
   assign pend_after = active ? (pend_now && !emit_scan) : match_pending_ff;
   assign emit_final = in_last_ff && !scan_done_ff && !emit_scan;
   assign emit       = emit_scan || emit_final;

   always_comb begin
      hit_in.found    = emit_scan || pend_after;
      hit_in.use_disp = emit_rel;
      hit_in.offset   = ADDR_W'(off_after);
      hit_in.disp_sum = {disp_word[DISP_W-1], disp_word} + (DISP_W+1)'(INSN_LEN);
   end

   assign hit_vld_in = hit_free ? (core_go && emit) : hit_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff        <= 1'b0;
         hit_vld_ff       <= 1'b0;
         bytes_seen_ff    <= '0;
         match_pending_ff <= 1'b0;
         match_off_ff     <= '0;
         scan_done_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         hit_vld_ff <= hit_vld_in;
         if (core_go) begin
            if (in_last_ff) begin
               bytes_seen_ff    <= '0;
               match_pending_ff <= 1'b0;
               match_off_ff     <= '0;
               scan_done_ff     <= 1'b0;
            end else begin
               if (active) begin
                  bytes_seen_ff <= bytes_seen_ff + OFFSET_BITS'(1);
               end
               match_pending_ff <= pend_after;
               match_off_ff     <= off_after;
               scan_done_ff     <= scan_done_ff || emit_scan;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
      if (core_go && active) begin
         win_ff <= win_nx;
      end
      if (core_go && emit) begin
         hit_ff <= hit_in;
      end
   end

   assign hit_valid = hit_vld_ff;
   assign hit       = hit_ff;

endmodule

`default_nettype wire

@@ src/mbss_resolve.sv @@
// address sum and result register
`default_nettype none

module mbss_resolve import mbss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] region_start,
   input  logic              hit_valid,
   output logic              hit_ready,
   input  rslv_type          hit,
   mbss_rsp_if.source        rsp
);

   logic              out_vld_ff;
   logic              out_vld_in;
   logic              out_found_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [ADDR_W-1:0] out_addr_in;
   logic [ADDR_W-1:0] disp_ext;
   logic              out_free;

   assign out_free  = !out_vld_ff || rsp.ready;
   assign hit_ready = out_free;
   assign out_vld_in = out_free ? hit_valid : out_vld_ff;

   assign disp_ext = hit.use_disp ? ADDR_W'($signed(hit.disp_sum)) : '0;

   always_comb begin
      if (hit.found) begin
         out_addr_in = region_start + hit.offset + disp_ext;
      end else begin
         out_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_valid && out_free) begin
         out_found_ff <= hit.found;
         out_addr_ff  <= out_addr_in;
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.found         = out_found_ff;
   assign rsp.match_address = out_addr_ff;

endmodule

`default_nettype wire

@@ test/tb_masked_byte_signature_scanner.sv @@
// testbench for the masked byte signature scanner: directed and random regions, checked beat by beat
module tb_masked_byte_signature_scanner import mbss_pkg::*; ();

   localparam int CLOCK_HALF     = 4;      // 8 unit period
   localparam int RESET_CYCLES   = 4;
   localparam int TOTAL_BEATS    = 650;    // byte beats sent over the whole run
   localparam int SETTLE_CYCLES  = 6;      // margin for swallowed bytes still in the pipe
   localparam int LONG_HOLD      = 300;    // one long receiver stall to back the block up
   localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on any port
   localparam int NUM_CSR        = int'(CSR_REGION_START) + 1;
   localparam longint unsigned POSITION_LIMIT = (64'd1 << OFFSET_BITS_DEF) - 64'd1;

   typedef logic [BYTE_W-1:0] byte_list_type [$];

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } scan_result_type;

   // mirror of the scanner: registers, sliding window and per-region flags
   class scan_scoreboard;
      logic [ADDR_W-1:0]   pattern_low;
      logic [ADDR_W-1:0]   pattern_high;
      logic [CARE_W-1:0]   care_mask;
      logic [LENGTH_W-1:0] pattern_length;
      logic                relative_mode;
      logic [ADDR_W-1:0]   region_start;
      logic [BYTE_W-1:0]   window [PATTERN_MAX_DEF];   // newest byte at index 0
      longint unsigned     bytes_seen;
      longint unsigned     hit_offset;
      bit                  hit_pending;
      bit                  region_done;
      scan_result_type     expected_q [$];
      int                  errors;
      int                  results_checked;
      int                  hits;
      int                  rip_hits;
      int                  bytes_scanned;

      function new();
         pattern_low     = CFG_RESET.pattern_low_bytes;
         pattern_high    = CFG_RESET.pattern_high_bytes;
         care_mask       = CFG_RESET.care_bits;
         pattern_length  = CFG_RESET.pattern_length;
         relative_mode   = CFG_RESET.relative_mode;
         region_start    = CFG_RESET.region_start;
         errors          = 0;
         results_checked = 0;
         hits            = 0;
         rip_hits        = 0;
         bytes_scanned   = 0;
         clear_region();
      endfunction

      function void clear_region();
         foreach (window[i]) window[i] = '0;
         bytes_seen  = 0;
         hit_offset  = 0;
         hit_pending = 1'b0;
         region_done = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_PATTERN_LOW:  pattern_low    = value;
            CSR_PATTERN_HIGH: pattern_high   = value;
            CSR_CARE_BITS:    care_mask      = value[CARE_W-1:0];
            CSR_PATTERN_LEN:  pattern_length = value[LENGTH_W-1:0];
            CSR_RELATIVE:     relative_mode  = value[0];
            CSR_REGION_START: region_start   = value;
            default: ;
         endcase
      endfunction

      function logic [BYTE_W-1:0] pattern_byte(int k);
         if (k < 8) return pattern_low[8*k +: 8];
         return pattern_high[8*(k-8) +: 8];
      endfunction

      function int eff_length();
         if (pattern_length == 0) return 1;
         if (pattern_length > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
         return int'(pattern_length);
      endfunction

      // pattern byte k lines up with window entry len-1-k
      function bit window_matches(int len);
         for (int k = 0; k < len; k++) begin
            if (care_mask[k] && window[len - 1 - k] != pattern_byte(k)) return 1'b0;
         end
         return 1'b1;
      endfunction

      // accepted byte beat: advance the scan and queue the result it causes, if any
      function void note_byte(logic [BYTE_W-1:0] data, logic last);
         longint unsigned   n;
         int                len;
         int                idx;
         logic [DISP_W-1:0] rel;
         scan_result_type   res;
         bit                emitted;
         emitted = 1'b0;
         res     = '0;
         if (!region_done && bytes_seen < POSITION_LIMIT) begin
            n = bytes_seen;
            bytes_scanned++;
            for (int i = PATTERN_MAX_DEF - 1; i > 0; i--) window[i] = window[i-1];
            window[0]  = data;
            bytes_seen = n + 1;
            if (!hit_pending) begin
               len = eff_length();
               if (n + 1 >= len && window_matches(len)) begin
                  hit_offset  = n + 1 - len;
                  hit_pending = 1'b1;
               end
            end
            if (hit_pending && !relative_mode) begin
               res     = '{1'b1, region_start + hit_offset};
               emitted = 1'b1;
            end else if (hit_pending && n >= hit_offset + DISP_LAST) begin
               idx = int'(n - hit_offset - DISP_POS);
               if (idx > PATTERN_MAX_DEF - 1) idx = PATTERN_MAX_DEF - 1;
               if (idx < DISP_BYTES - 1) idx = DISP_BYTES - 1;
               rel = {window[idx-3], window[idx-2], window[idx-1], window[idx]};
               res = '{1'b1, region_start + hit_offset
                             + {{(ADDR_W-DISP_W){rel[DISP_W-1]}}, rel} + ADDR_W'(INSN_LEN)};
               emitted = 1'b1;
               rip_hits++;
            end
            if (emitted) begin
               region_done = 1'b1;
               hit_pending = 1'b0;
            end
         end
         if (last) begin
            if (!region_done) begin
               if (hit_pending) res = '{1'b1, region_start + hit_offset};
               else res = '{1'b0, '0};
               emitted = 1'b1;
            end
            clear_region();
         end
         if (emitted) begin
            expected_q = {expected_q, res};
            if (res.found) hits++;
         end
      endfunction

      function void check_result(logic found, logic [ADDR_W-1:0] match_address);
         scan_result_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: found=%0b match_address=%h",
                   found, match_address);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, found);
            errors++;
         end
         if (match_address !== want.match_address) begin
            $error("match_address: expected %h, got %h", want.match_address, match_address);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   bit             reset_done   = 1'b0;
   int             hold_request = 0;     // set by the stimulus, consumed by the receiver
   int             regions      = 0;
   int             configs      = 0;
   int             long_holds   = 0;
   int             beats_sent   = 0;
   scan_scoreboard sb;

   mbss_req_if req_bus ();
   mbss_rsp_if rsp_bus ();

   masked_byte_signature_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // write all six registers back to back; we stays high across the burst
   task automatic load_config(input logic [CSR_DATA_W-1:0] low, high, care, len, rel, start);
      logic [CSR_DATA_W-1:0] image [NUM_CSR];
      csr_index_type         idx;
      image[CSR_PATTERN_LOW]  = low;
      image[CSR_PATTERN_HIGH] = high;
      image[CSR_CARE_BITS]    = care;
      image[CSR_PATTERN_LEN]  = len;
      image[CSR_RELATIVE]     = rel;
      image[CSR_REGION_START] = start;
      idx = idx.first();
      do begin
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_data  <= image[idx];
         @(posedge clock);
         sb.write_reg(idx, image[idx]);
         idx = idx.next();
      end while (idx != idx.first());
      csr_we <= 1'b0;
      configs++;
   endtask

   // one region, one beat per byte; eager regions go out with no gaps
   task automatic send_region(input byte_list_type bytes, input bit eager);
      int gap;
      foreach (bytes[i]) begin
         gap = eager ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.valid     <= 1'b1;
         req_bus.data_byte <= bytes[i];
         req_bus.last_byte <= (i == bytes.size() - 1);
         do @(posedge clock); while (req_bus.ready !== 1'b1);
         sb.note_byte(bytes[i], i == bytes.size() - 1);
         beats_sent++;
      end
      regions++;
   endtask

   // drain: all results in, then a settle wait for bytes still in the pipe
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stall per beat, calm stretches, and one long hold on request
   initial begin
      int stall;
      int calm_left;
      calm_left = 0;
      rsp_bus.ready <= 1'b0;
      wait (reset_done);
      forever begin
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
            long_holds++;
         end else if (calm_left > 0) begin
            stall = 0;
            calm_left--;
         end else begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(8, 40);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         sb.check_result(rsp_bus.found, rsp_bus.match_address);
      end
   end

   // watchdog: any beat or register write counts as progress
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) || csr_we === 1'b1) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, sb.expected_q.size());
      $display("TB_ERROR");
      $finish;
   end

   // stimulus
   initial begin
      byte_list_type         region;
      logic [CSR_DATA_W-1:0] low;
      logic [CSR_DATA_W-1:0] high;
      logic [CSR_DATA_W-1:0] care;
      logic [CSR_DATA_W-1:0] len;
      logic [CSR_DATA_W-1:0] start;
      int                    eff;
      int                    at;
      int                    size;
      int                    left_in_phase;
      bit                    plant;
      bit                    alphabet;
      bit                    pressure_done;

      sb = new();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_PATTERN_LOW;
      csr_data          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset      <= 1'b0;
      reset_done = 1'b1;

      // reset registers: one-byte pattern, nothing compared, every region hits at offset 0
      region = '{8'hFF};
      send_region(region, 1'b0);
      region = '{8'h00, 8'hAB, 8'h55};   // bytes after the hit are swallowed
      send_region(region, 1'b0);
      settle();

      // zero length acts as length one with byte 0 compared; address wraps past the top
      load_config(64'h34, '0, 64'hFFFF, 64'd0, 64'd0, '1);
      region = '{8'h12, 8'h34};
      send_region(region, 1'b1);
      settle();

      // length above the window saturates; a region shorter than the pattern never hits
      load_config('1, '1, 64'hFFFF, 64'd31, 64'd0, 64'h1000);
      region = '{8'hFF, 8'hFF, 8'hFF};
      send_region(region, 1'b0);
      settle();

      // rip-relative: 48 8b 05 then a rel32 with its sign bit set
      load_config(64'h05_8B48, '0, 64'h7, 64'd3, 64'd1, 64'h0000_7FF0_0000_1000);
      region = '{8'h90, 8'h48, 8'h8B, 8'h05, 8'h10, 8'h00, 8'h00, 8'h80, 8'hCC};
      send_region(region, 1'b0);
      // region ends before the displacement is in: plain address
      region = '{8'h48, 8'h8B, 8'h05, 8'h01};
      send_region(region, 1'b0);
      // no match at all
      region = '{8'h00};
      send_region(region, 1'b0);

      // random part: phases of a few regions under one register setting
      left_in_phase = 0;
      pressure_done = 1'b0;
      while (beats_sent < TOTAL_BEATS) begin
         if (left_in_phase == 0) begin
            settle();
            if (!pressure_done) begin
               // every single-byte region yields a result while the receiver holds off,
               // so the result side backs up and the block has to stall its input
               load_config({$urandom, $urandom}, {$urandom, $urandom}, 64'd0, 64'd1, 64'd0,
                           {$urandom, $urandom});
               hold_request = LONG_HOLD;
               repeat (40) begin
                  region = '{8'($urandom)};
                  send_region(region, 1'b1);
               end
               settle();
               pressure_done = 1'b1;
            end
            case ($urandom_range(0, 7))
               0:       low = '0;
               1:       low = '1;
               default: low = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 7))
               0:       high = '0;
               1:       high = '1;
               default: high = {$urandom, $urandom};
            endcase
            // care mask: none, all, random with junk above bit 15, or plain random
            case ($urandom_range(0, 4))
               0:       care = '0;
               1:       care = 64'hFFFF;
               2:       care = {$urandom, $urandom};
               default: care = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 9))
               0:       len = '0;
               1:       len = $urandom_range(17, 31);
               2:       len = 64'd16;
               default: len = $urandom_range(1, 16);
            endcase
            // region start: bottom, top, just under the top (wrap), or anywhere
            case ($urandom_range(0, 5))
               0:       start = '0;
               1:       start = '1;
               2:       start = '1 - $urandom_range(0, 64);
               default: start = {$urandom, $urandom};
            endcase
            load_config(low, high, care, len, 64'($urandom_range(0, 1)), start);
            left_in_phase = $urandom_range(3, 8);
         end

         // mostly regions with the pattern planted at a random spot, don't-care bytes random
         eff      = sb.eff_length();
         alphabet = $urandom_range(0, 1);
         plant    = $urandom_range(0, 3) != 0;
         at       = $urandom_range(0, 10);
         if ($urandom_range(0, 15) == 0) size = $urandom_range(40, 90);
         else if (plant) size = at + eff + $urandom_range(0, 10);
         else size = $urandom_range(1, 24);
         if (size < at + eff) plant = 1'b0;
         region.delete();
         // pattern-byte alphabet gives near misses and overlapping partial matches
         repeat (size) begin
            region = {region,
                      (alphabet ? sb.pattern_byte($urandom_range(0, 15)) : 8'($urandom))};
         end
         if (plant) begin
            for (int k = 0; k < eff; k++) begin
               if (sb.care_mask[k]) region[at + k] = sb.pattern_byte(k);
            end
         end
         send_region(region, $urandom_range(0, 3) == 0);
         left_in_phase--;
      end

      settle();
      $display("sent %0d byte beats (%0d scanned) in %0d regions under %0d settings, %0d long stall(s)",
               beats_sent, sb.bytes_scanned, regions, configs, long_holds);
      $display("checked %0d results: %0d hits, %0d resolved through rel32, %0d failures",
               sb.results_checked, sb.hits, sb.rip_hits, sb.errors);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/mbss_pkg.sv
src/mbss_req_if.sv
src/mbss_rsp_if.sv
src/mbss_csr.sv
src/mbss_scan.sv
src/mbss_resolve.sv
src/masked_byte_signature_scanner.sv
test/tb_masked_byte_signature_scanner.sv
